/* rtl/gww_pkg.sv */
package gww_pkg;

	localparam int MAX_WIDTH = 32;
	localparam int PTR_W     = $clog2(MAX_WIDTH);
	localparam int DEPTH     = 1 << PTR_W;
	localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
	localparam int CFG_W     = 6;

	localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(32);
	localparam logic [7:0]       SPACE_CHAR  = 8'h20;

	// what the send loop is walking through
	localparam logic [1:0] MD_FLUSH = 2'd0;
	localparam logic [1:0] MD_CHUNK = 2'd1;
	localparam logic [1:0] MD_WORD  = 2'd2;

	// what goes into the output register
	localparam logic [1:0] LD_NONE  = 2'd0;
	localparam logic [1:0] LD_BYTE  = 2'd1;
	localparam logic [1:0] LD_SPACE = 2'd2;
	localparam logic [1:0] LD_MARK  = 2'd3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_last;
	} text_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       line_start;
		logic       byte_valid;
		logic       run_end;
		logic       text_end;
	} wrap_result_t;

	typedef struct packed {
		logic       take;
		logic       append;
		logic       from_in;
		logic       after_flush;
		logic       rd;
		logic [1:0] load;
		logic       start;
		logic [1:0] mode;
		logic       join_line;
		logic       finish;
	} gww_cmd_t;

	typedef struct packed {
		logic in_space;
		logic in_last;
		logic in_long;
		logic wl_zero;
		logic chunk_mode;
		logic ll_zero;
		logic fits;
		logic last_q;
		logic flushing;
		logic send_last;
		logic out_free;
	} gww_stat_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == SPACE_CHAR) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

endpackage

/* rtl/gww_ram.sv */
module gww_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/gww_ctrl.sv */
module gww_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_ready,
	input  gww_pkg::gww_stat_t  st,
	output gww_pkg::gww_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RD     = 3'd1;
	localparam logic [2:0] S_WR     = 3'd2;
	localparam logic [2:0] S_APPEND = 3'd3;
	localparam logic [2:0] S_END    = 3'd4;
	localparam logic [2:0] S_SEP    = 3'd5;
	localparam logic [2:0] S_MARK   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_comb begin
		cmd        = '0;
		state_nx   = state_q;
		text_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				text_ready = 1'b1;
				if (text_valid) begin
					cmd.take = 1'b1;
					if (st.in_space) begin
						state_nx = S_END;
					end else if (st.in_long) begin
						// buffered word already fills a line: chunk it out first
						state_nx = S_RD;
					end else begin
						cmd.append  = 1'b1;
						cmd.from_in = 1'b1;
						state_nx    = st.in_last ? S_END : S_IDLE;
					end
				end
			end
			S_RD: begin
				cmd.rd   = 1'b1;
				state_nx = S_WR;
			end
			S_WR: begin
				if (st.out_free) begin
					cmd.load = gww_pkg::LD_BYTE;
					if (!st.send_last) begin
						state_nx = S_RD;
					end else if (st.flushing) begin
						state_nx = S_APPEND;
					end else begin
						cmd.finish = 1'b1;
						state_nx   = S_IDLE;
					end
				end
			end
			S_APPEND: begin
				cmd.append      = 1'b1;
				cmd.after_flush = 1'b1;
				state_nx        = st.last_q ? S_END : S_IDLE;
			end
			S_END: begin
				if (st.wl_zero) begin
					if (st.last_q) begin
						state_nx = S_MARK;
					end else begin
						cmd.finish = 1'b1;
						state_nx   = S_IDLE;
					end
				end else begin
					cmd.start = 1'b1;
					state_nx  = S_RD;
					if (st.chunk_mode) begin
						cmd.mode = gww_pkg::MD_CHUNK;
					end else begin
						cmd.mode = gww_pkg::MD_WORD;
						if (!st.ll_zero && st.fits) begin
							cmd.join_line = 1'b1;
							state_nx      = S_SEP;
						end
					end
				end
			end
			S_SEP: begin
				if (st.out_free) begin
					cmd.load = gww_pkg::LD_SPACE;
					state_nx = S_RD;
				end
			end
			S_MARK: begin
				if (st.out_free) begin
					cmd.load   = gww_pkg::LD_MARK;
					cmd.finish = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

/* rtl/gww_dp.sv */
module gww_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gww_pkg::text_item_t            text,
	input  logic                           cfg_valid,
	input  logic [gww_pkg::CFG_W-1:0]      cfg_data,
	input  gww_pkg::gww_cmd_t              cmd,
	output gww_pkg::gww_stat_t             st,
	output logic                           result_valid,
	input  logic                           result_ready,
	output gww_pkg::wrap_result_t          result
);

	localparam int CW = gww_pkg::CNT_W;
	localparam int PW = gww_pkg::PTR_W;

	logic [gww_pkg::CFG_W-1:0] width_q;
	logic [CW-1:0]             wl_q;
	logic [CW-1:0]             ll_q;
	logic                      lwm_q;
	logic [PW-1:0]             base_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             col_q;
	logic [1:0]                md_q;
	logic                      join_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      out_valid_q;
	gww_pkg::wrap_result_t     out_q;

	logic [CW-1:0] w;
	logic [CW-1:0] idx_nx;
	logic [CW-1:0] rem;
	logic [CW:0]   join_len;
	logic          col_end;
	logic          send_last;
	logic          out_free;
	logic [PW-1:0] waddr;
	logic [PW-1:0] raddr;
	logic [7:0]    wdata;
	logic [7:0]    rdata;
	gww_pkg::wrap_result_t res_nx;

	// effective width, saturated into 1..MAX_WIDTH
	always_comb begin
		if (width_q == '0) begin
			w = CW'(1);
		end else if (int'(width_q) > gww_pkg::MAX_WIDTH) begin
			w = CW'(gww_pkg::MAX_WIDTH);
		end else begin
			w = CW'(width_q);
		end
	end

	assign idx_nx   = idx_q + CW'(1);
	assign rem      = wl_q - idx_nx;
	assign col_end  = (col_q == w - CW'(1));
	assign join_len = {1'b0, ll_q} + (CW+1)'(1) + {1'b0, wl_q};
	assign out_free = !out_valid_q || result_ready;

	// a flush stops at the first chunk boundary with less than a line left
	assign send_last = (md_q == gww_pkg::MD_FLUSH) ? (col_end && (rem < w))
	                                               : (idx_nx == wl_q);

	always_comb begin
		st            = '0;
		st.in_space   = gww_pkg::is_blank(text.text_byte);
		st.in_last    = text.text_last;
		st.in_long    = (wl_q >= w);
		st.wl_zero    = (wl_q == '0);
		st.chunk_mode = lwm_q || (wl_q > w);
		st.ll_zero    = (ll_q == '0);
		st.fits       = (join_len <= {1'b0, w});
		st.last_q     = last_q;
		st.flushing   = (md_q == gww_pkg::MD_FLUSH);
		st.send_last  = send_last;
		st.out_free   = out_free;
	end

	// circular word buffer: dropping flushed chunks moves base, not data
	assign waddr = base_q + wl_q[PW-1:0];
	assign raddr = base_q + idx_q[PW-1:0];
	assign wdata = cmd.from_in ? text.text_byte : byte_q;

	gww_ram #(
		.WIDTH(8),
		.DEPTH(gww_pkg::DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		res_nx = '0;
		case (cmd.load)
			gww_pkg::LD_BYTE: begin
				res_nx.out_byte   = rdata;
				res_nx.line_start = (md_q == gww_pkg::MD_WORD) ? ((idx_q == '0) && !join_q)
				                                               : (col_q == '0);
				res_nx.byte_valid = 1'b1;
				res_nx.run_end    = send_last && ((md_q != gww_pkg::MD_FLUSH) || !last_q);
				res_nx.text_end   = send_last && (md_q != gww_pkg::MD_FLUSH) && last_q;
			end
			gww_pkg::LD_SPACE: begin
				res_nx.out_byte   = gww_pkg::SPACE_CHAR;
				res_nx.byte_valid = 1'b1;
			end
			gww_pkg::LD_MARK: begin
				res_nx.run_end  = 1'b1;
				res_nx.text_end = 1'b1;
			end
			default: begin
				res_nx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= gww_pkg::WIDTH_RESET;
			wl_q        <= '0;
			ll_q        <= '0;
			lwm_q       <= 1'b0;
			base_q      <= '0;
			idx_q       <= '0;
			col_q       <= '0;
			md_q        <= gww_pkg::MD_FLUSH;
			join_q      <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				width_q <= cfg_data;
			end
			if (cmd.take) begin
				last_q <= text.text_last;
				idx_q  <= '0;
				col_q  <= '0;
				md_q   <= gww_pkg::MD_FLUSH;
			end
			if (cmd.append) begin
				if (cmd.after_flush) begin
					base_q <= base_q + idx_q[PW-1:0];
					wl_q   <= wl_q - idx_q + CW'(1);
					lwm_q  <= 1'b1;
					ll_q   <= '0;
				end else begin
					wl_q <= wl_q + CW'(1);
				end
			end
			if (cmd.start) begin
				idx_q  <= '0;
				col_q  <= '0;
				md_q   <= cmd.mode;
				join_q <= cmd.join_line;
				if (cmd.mode == gww_pkg::MD_CHUNK) begin
					ll_q <= '0;
				end else if (cmd.join_line) begin
					ll_q <= join_len[CW-1:0];
				end else begin
					ll_q <= wl_q;
				end
			end
			if (cmd.load == gww_pkg::LD_BYTE) begin
				idx_q <= idx_nx;
				col_q <= col_end ? '0 : col_q + CW'(1);
			end
			if (cmd.finish) begin
				wl_q  <= '0;
				lwm_q <= 1'b0;
				if (last_q) begin
					ll_q <= '0;
				end
			end
			if (cmd.load != gww_pkg::LD_NONE) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= text.text_byte;
		end
		if (cmd.load != gww_pkg::LD_NONE) begin
			out_q <= res_nx;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* rtl/greedy_word_wrap_top.sv */
// A word byte is appended with no transfer, unless the buffered word already fills
// a line and is chunked out first. A separator or final byte adds a decision state,
// then each byte sent takes a buffer read and then an output register load, as the
// word buffer read is registered; a joining space, the end marker and the append
// after a chunk flush each have their own state. Result back-pressure holds each
// output load. arst_n clears control state, line_width to 32.
module greedy_word_wrap_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           text_valid,
	output logic                           text_ready,
	input  gww_pkg::text_item_t            text,
	output logic                           result_valid,
	input  logic                           result_ready,
	output gww_pkg::wrap_result_t          result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gww_pkg::CFG_W-1:0]      cfg_data
);

	gww_pkg::gww_cmd_t  cmd;
	gww_pkg::gww_stat_t st;

	assign cfg_ready = 1'b1;

	gww_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.st        (st),
		.cmd       (cmd)
	);

	gww_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.st          (st),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	a_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_valid |-> result.run_end && result.text_end)
		else $error("end marker without run_end/text_end");

	a_text_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.text_end |-> result.run_end)
		else $error("text_end without run_end");

	a_line_start_real: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.line_start |-> result.byte_valid)
		else $error("line_start on marker item");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_ready && text.text_last |=> !text_ready)
		else $error("final byte accepted without end-of-text handling");

endmodule

/* tb/tb_greedy_word_wrap_top.sv */
`timescale 1ns / 1ps

module tb_greedy_word_wrap_top;

	localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up
	localparam int LONG_HOLD    = 400;   // receiver back-pressure stretch
	localparam int SETTLE       = 16;    // word bytes cause no transfer, allow them to land
	localparam int MAX_PER_STEP = gww_pkg::MAX_WIDTH + 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  text_valid = 1'b0;
	logic                  text_ready;
	gww_pkg::text_item_t   text = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	gww_pkg::wrap_result_t result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [gww_pkg::CFG_W-1:0] cfg_data = '0;

	greedy_word_wrap_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text         (text),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// wrap predictor state
	logic [7:0]       word_bytes [gww_pkg::MAX_WIDTH];
	int               word_len = 0;
	int               line_len = 0;
	bit               long_word = 1'b0;
	int               chunk_cnt = 0;
	logic [gww_pkg::CFG_W-1:0] width_setting = gww_pkg::WIDTH_RESET;

	gww_pkg::wrap_result_t emitted [$];
	gww_pkg::wrap_result_t wrap_expect [$];
	gww_pkg::text_item_t   text_queue [$];

	bit failed = 1'b0;
	int idle_odds = 0;      // 0: no random idling, else 1 in idle_odds
	bit calm = 1'b0;
	bit stall_req = 1'b0;
	bit stall_done = 1'b0;

	function automatic int line_cap();
		int w;
		w = width_setting;
		if (w < 1) w = 1;
		if (w > gww_pkg::MAX_WIDTH) w = gww_pkg::MAX_WIDTH;
		return w;
	endfunction

	function automatic bit blank_char(input logic [7:0] c);
		return (c == gww_pkg::SPACE_CHAR) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void emit_byte(input logic [7:0] b, input bit ls);
		gww_pkg::wrap_result_t r;
		r.out_byte   = b;
		r.line_start = ls;
		r.byte_valid = 1'b1;
		r.run_end    = 1'b0;
		r.text_end   = 1'b0;
		if (emitted.size() < MAX_PER_STEP)
			emitted.insert(emitted.size(), r);
	endfunction

	function automatic void emit_chunks(input int count, input int w);
		bit first;
		for (int i = 0; i < count && i < gww_pkg::MAX_WIDTH; i++) begin
			first = (i % w) == 0;
			if (first && chunk_cnt < 63)
				chunk_cnt++;
			emit_byte(word_bytes[i], first);
		end
	endfunction

	function automatic void emit_word(input bit ls);
		for (int i = 0; i < word_len && i < gww_pkg::MAX_WIDTH; i++)
			emit_byte(word_bytes[i], (i == 0) ? ls : 1'b0);
	endfunction

	function automatic void close_word(input int w);
		if (word_len != 0) begin
			if (long_word || word_len > w) begin
				emit_chunks(word_len, w);
				line_len = 0;
			end else if (line_len == 0) begin
				emit_word(1'b1);
				line_len = word_len;
			end else if (line_len + 1 + word_len <= w) begin
				emit_byte(gww_pkg::SPACE_CHAR, 1'b0);
				emit_word(1'b0);
				line_len += 1 + word_len;
			end else begin
				emit_word(1'b1);
				line_len = word_len;
			end
		end
		word_len = 0;
		long_word = 1'b0;
		chunk_cnt = 0;
	endfunction

	function automatic void wrap_predict(input gww_pkg::text_item_t it);
		int w;
		int q;
		gww_pkg::wrap_result_t r;
		w = line_cap();
		emitted.delete();
		if (blank_char(it.text_byte)) begin
			close_word(w);
		end else begin
			if (word_len >= w) begin
				q = (word_len / w) * w;
				long_word = 1'b1;
				line_len = 0;
				emit_chunks(q, w);
				for (int i = 0; i < word_len - q; i++)
					word_bytes[i] = word_bytes[i + q];
				word_len -= q;
			end
			if (word_len < gww_pkg::MAX_WIDTH) begin
				word_bytes[word_len] = it.text_byte;
				word_len++;
			end
		end
		if (it.text_last) begin
			close_word(w);
			if (emitted.size() == 0) begin
				r = '0;
				emitted.insert(emitted.size(), r);
			end
			r = emitted[emitted.size() - 1];
			r.text_end = 1'b1;
			emitted[emitted.size() - 1] = r;
			word_len = 0;
			line_len = 0;
			long_word = 1'b0;
			chunk_cnt = 0;
		end
		if (emitted.size() > 0) begin
			r = emitted[emitted.size() - 1];
			r.run_end = 1'b1;
			emitted[emitted.size() - 1] = r;
		end
		foreach (emitted[i])
			wrap_expect.insert(wrap_expect.size(), emitted[i]);
	endfunction

	// ---------------------------------------------------------------
	// text driver
	int src_gap = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
		end else begin
			if (text_valid && text_ready)
				wrap_predict(text);
			if (!text_valid || text_ready) begin
				if (src_gap > 0) begin
					src_gap--;
					text_valid <= 1'b0;
				end else if (text_queue.size() > 0) begin
					if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
						src_gap = $urandom_range(0, 11);
						text_valid <= 1'b0;
					end else begin
						text <= text_queue.pop_front();
						text_valid <= 1'b1;
					end
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor
	int sink_gap = 0;
	int hold_left = 0;

	task automatic check_result(input gww_pkg::wrap_result_t got);
		gww_pkg::wrap_result_t want;
		if (wrap_expect.size() == 0) begin
			$error("unexpected result: out_byte %02h line_start %0b byte_valid %0b",
				got.out_byte, got.line_start, got.byte_valid);
			failed = 1'b1;
		end else begin
			want = wrap_expect.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				failed = 1'b1;
			end
			if (got.line_start !== want.line_start) begin
				$error("line_start: expected %0b, got %0b", want.line_start, got.line_start);
				failed = 1'b1;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
				failed = 1'b1;
			end
			if (got.run_end !== want.run_end) begin
				$error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
				failed = 1'b1;
			end
			if (got.text_end !== want.text_end) begin
				$error("text_end: expected %0b, got %0b", want.text_end, got.text_end);
				failed = 1'b1;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready)
				check_result(result);
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (stall_req && !stall_done) begin
				stall_done = 1'b1;
				hold_left = LONG_HOLD;
				result_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				result_ready <= 1'b0;
			end else if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
				sink_gap = $urandom_range(0, 11);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: no transfer on any channel for too long
	int quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && text_ready) || (result_valid && result_ready) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	task automatic add_byte(input logic [7:0] b, input bit last);
		gww_pkg::text_item_t it;
		it.text_byte = b;
		it.text_last = last;
		text_queue.insert(text_queue.size(), it);
	endtask

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (blank_char(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic logic [7:0] blank_pick();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = 8'h09 + 8'($urandom_range(0, 4));
			default: c = gww_pkg::SPACE_CHAR;
		endcase
		return c;
	endfunction

	task automatic add_word(input int len);
		for (int i = 0; i < len; i++)
			add_byte(word_char(), 1'b0);
	endtask

	task automatic wait_idle();
		while (text_queue.size() != 0 || text_valid || wrap_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_width(input logic [gww_pkg::CFG_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		width_setting = v;
	endtask

	// texts of random words; some end without a final byte so the next
	// width change lands mid-word
	task automatic add_texts(input int count);
		int made;
		int nwords;
		int len;
		int w;
		w = line_cap();
		made = 0;
		while (made < count) begin
			nwords = $urandom_range(1, 6);
			for (int k = 0; k < nwords && made < count; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					add_byte(8'($urandom_range(0, 255)), 1'b0);
					made++;
				end
				if ($urandom_range(0, 4) == 0)
					len = $urandom_range(w + 1, w + w / 2 + 2);
				else
					len = $urandom_range(1, w);
				add_word(len);
				made += len;
				for (int j = $urandom_range(1, 3); j > 0; j--) begin
					add_byte(blank_pick(), 1'b0);
					made++;
				end
			end
			len = 1;
			case ($urandom_range(0, 4))
				0, 1: add_byte(word_char(), 1'b1);
				2, 3: add_byte(blank_pick(), 1'b1);
				default: begin
					len = $urandom_range(1, 3);
					add_word(len);
				end
			endcase
			made += len;
		end
	endtask

	initial begin
		logic [gww_pkg::CFG_W-1:0] widths [8];
		widths[0] = 6'd32;
		widths[1] = 6'd1;
		widths[2] = 6'd63;
		widths[3] = 6'd33;
		widths[4] = 6'd2;
		widths[5] = 6'd12;
		widths[6] = 6'd0;
		widths[7] = 6'd7;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// boundary bytes, every blank kind, two words joined on one line
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h09, 1'b0);
		add_byte(8'h0A, 1'b0);
		add_byte(8'h0B, 1'b0);
		add_byte(8'h0C, 1'b0);
		add_byte(8'h0D, 1'b0);
		add_byte(gww_pkg::SPACE_CHAR, 1'b0);
		add_byte(8'h08, 1'b0);
		add_byte(8'h0E, 1'b0);
		add_byte(gww_pkg::SPACE_CHAR, 1'b1);
		// end of text with nothing pending: marker only
		add_byte(gww_pkg::SPACE_CHAR, 1'b1);
		// open a 6-byte line, then shrink the width below it
		add_word(6);
		add_byte(gww_pkg::SPACE_CHAR, 1'b0);
		write_width(6'd3);
		add_word(2);
		add_byte(gww_pkg::SPACE_CHAR, 1'b0);
		// gather a word, then drop to width 0 (acts as 1) mid-word
		add_word(5);
		write_width(6'd0);
		add_byte(8'h7F, 1'b1);

		for (int p = 0; p < 8; p++) begin
			write_width(p == 5 ? 6'($urandom_range(0, 63)) : widths[p]);
			idle_odds = (p % 2 == 0) ? 3 : 8;
			if (p == 7)
				calm = 1'b1;
			if (p == 2)
				stall_req = 1'b1;
			add_texts(48);
		end

		while (text_queue.size() != 0 || text_valid || wrap_expect.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
rtl/gww_pkg.sv
rtl/gww_ram.sv
rtl/gww_ctrl.sv
rtl/gww_dp.sv
rtl/greedy_word_wrap_top.sv
tb/tb_greedy_word_wrap_top.sv
